FILE: hdl/bed_pkg.sv
package bed_pkg;

	localparam int TickWidthDef = 32;
	localparam int TickInW      = 32;
	localparam int CfgIndexW    = 3;
	localparam int CfgDataW     = 16;
	localparam int DebCountW    = 9;

	localparam logic [CfgIndexW-1:0] REG_PRESS_LEVEL      = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_DEB_PERIOD       = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_DEBOUNCE_REPEATS = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_HOLD_PERIOD      = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_TAP_WINDOW       = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_EVENT_ENABLE     = 3'd5;

	localparam logic        PRESS_LEVEL_RST      = 1'b0;
	localparam logic [15:0] DEB_PERIOD_RST       = 16'd20;
	localparam logic [7:0]  DEBOUNCE_REPEATS_RST = 8'd1;
	localparam logic [15:0] HOLD_PERIOD_RST      = 16'd1000;
	localparam logic [15:0] TAP_WINDOW_RST       = 16'd200;
	localparam logic [5:0]  EVENT_ENABLE_RST     = 6'h3F;

	typedef logic [2:0] event_t;

	localparam event_t EV_NONE   = 3'd0;
	localparam event_t EV_UP     = 3'd1;
	localparam event_t EV_DOWN   = 3'd2;
	localparam event_t EV_LSTART = 3'd3;
	localparam event_t EV_LHOLD  = 3'd4;
	localparam event_t EV_LSTOP  = 3'd5;
	localparam event_t EV_TAP    = 3'd6;

	typedef struct packed {
		logic        press_level;
		logic [15:0] deb_period;
		logic [7:0]  debounce_repeats;
		logic [15:0] hold_period;
		logic [15:0] tap_window;
		logic [5:0]  event_enable;
	} cfg_t;

	// Request to clear the detector state; the debounced level restarts at idle_level.
	typedef struct packed {
		logic clear;
		logic idle_level;
	} clr_t;

endpackage

FILE: hdl/bed_config.sv
module bed_config (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bed_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [bed_pkg::CfgDataW-1:0]  cfg_data,
	output bed_pkg::cfg_t                 cfg,
	output bed_pkg::clr_t                 clr
);
	import bed_pkg::*;

	cfg_t cfg_q;
	logic hit;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_comb begin
		hit = 1'b0;
		case (cfg_index)
			REG_PRESS_LEVEL, REG_DEB_PERIOD, REG_DEBOUNCE_REPEATS,
			REG_HOLD_PERIOD, REG_TAP_WINDOW, REG_EVENT_ENABLE: hit = 1'b1;
			default: hit = 1'b0;
		endcase
	end

	// A write to a known register clears the detector, using the new pressed level.
	always_comb begin
		clr.clear      = cfg_valid && hit;
		clr.idle_level = (cfg_index == REG_PRESS_LEVEL) ? ~cfg_data[0] : ~cfg_q.press_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level      <= PRESS_LEVEL_RST;
			cfg_q.deb_period       <= DEB_PERIOD_RST;
			cfg_q.debounce_repeats <= DEBOUNCE_REPEATS_RST;
			cfg_q.hold_period      <= HOLD_PERIOD_RST;
			cfg_q.tap_window       <= TAP_WINDOW_RST;
			cfg_q.event_enable     <= EVENT_ENABLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PRESS_LEVEL:      cfg_q.press_level      <= cfg_data[0];
				REG_DEB_PERIOD:       cfg_q.deb_period       <= cfg_data;
				REG_DEBOUNCE_REPEATS: cfg_q.debounce_repeats <= cfg_data[7:0];
				REG_HOLD_PERIOD:      cfg_q.hold_period      <= cfg_data;
				REG_TAP_WINDOW:       cfg_q.tap_window       <= cfg_data;
				REG_EVENT_ENABLE:     cfg_q.event_enable     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/bed_debounce.sv
module bed_debounce #(
	parameter int TICK_WIDTH = bed_pkg::TickWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bed_pkg::cfg_t         cfg,
	input  bed_pkg::clr_t         clr,
	input  logic                  step,
	input  logic [TICK_WIDTH-1:0] tick,
	input  logic                  raw_level,
	output logic                  level
);
	import bed_pkg::*;

	logic                  level_q;
	logic                  busy_q;
	logic [TICK_WIDTH-1:0] start_q;
	logic [DebCountW-1:0]  count_q;

	logic                  level_d;
	logic                  busy_d;
	logic [TICK_WIDTH-1:0] start_d;
	logic [DebCountW-1:0]  count_d;
	logic [TICK_WIDTH-1:0] elapsed;

	always_comb begin
		level_d = level_q;
		busy_d  = busy_q;
		start_d = start_q;
		count_d = count_q;
		elapsed = '0;
		if (cfg.deb_period == 16'd0) begin
			level_d = raw_level;
		end else begin
			if (raw_level == level_q) begin
				busy_d = 1'b0;
			end else if (!busy_q) begin
				busy_d  = 1'b1;
				start_d = tick;
			end
			elapsed = tick - start_d;
			// The interval is done; count it and restart the interval timer.
			if (busy_d && ({{(TICK_WIDTH-16){1'b0}}, cfg.deb_period} <= elapsed)) begin
				count_d = count_q + 1'b1;
				if (count_d > {1'b0, cfg.debounce_repeats}) begin
					busy_d  = 1'b0;
					level_d = raw_level;
					count_d = '0;
				end
				start_d = tick;
			end
		end
	end

	assign level = level_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= ~PRESS_LEVEL_RST;
			busy_q  <= 1'b0;
			start_q <= '0;
			count_q <= '0;
		end else if (clr.clear) begin
			level_q <= clr.idle_level;
			busy_q  <= 1'b0;
			start_q <= '0;
			count_q <= '0;
		end else if (step) begin
			level_q <= level_d;
			busy_q  <= busy_d;
			start_q <= start_d;
			count_q <= count_d;
		end
	end

endmodule

FILE: hdl/bed_fsm.sv
module bed_fsm #(
	parameter int TICK_WIDTH = bed_pkg::TickWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bed_pkg::cfg_t         cfg,
	input  bed_pkg::clr_t         clr,
	input  logic                  step,
	input  logic [TICK_WIDTH-1:0] tick,
	input  logic                  act,
	output bed_pkg::event_t       event_res,
	output logic [7:0]            tap_count
);
	import bed_pkg::*;

	localparam logic [2:0] ST_INIT     = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_DOWN     = 3'd2;
	localparam logic [2:0] ST_PRESSED  = 3'd3;
	localparam logic [2:0] ST_LONG     = 3'd4;
	localparam logic [2:0] ST_UP       = 3'd5;
	localparam logic [2:0] ST_RELEASED = 3'd6;

	logic [2:0]            state_q;
	logic [TICK_WIDTH-1:0] event_tick_q;
	logic [7:0]            tap_q;

	logic [2:0]            state_d;
	logic [TICK_WIDTH-1:0] event_tick_d;
	logic [7:0]            tap_d;
	logic [TICK_WIDTH-1:0] diff;
	logic [TICK_WIDTH-1:0] long_term;
	logic [TICK_WIDTH-1:0] tap_term;
	event_t                ev;
	logic                  tap_shown;

	assign diff      = tick - event_tick_q;
	assign long_term = {{(TICK_WIDTH-16){1'b0}}, cfg.hold_period};
	assign tap_term  = {{(TICK_WIDTH-16){1'b0}}, cfg.tap_window};

	always_comb begin
		state_d      = state_q;
		event_tick_d = event_tick_q;
		tap_d        = tap_q;
		ev           = EV_NONE;
		tap_shown    = 1'b0;
		case (state_q)
			ST_INIT: begin
				if (act) begin
					state_d = ST_DOWN;
				end else begin
					ev      = EV_UP;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (act) state_d = ST_DOWN;
			end
			ST_DOWN: begin
				ev           = EV_DOWN;
				state_d      = ST_PRESSED;
				event_tick_d = tick;
			end
			ST_PRESSED: begin
				if (!act) begin
					state_d = ST_UP;
				end else if (diff > long_term) begin
					ev      = EV_LSTART;
					tap_d   = '0;
					state_d = ST_LONG;
				end
			end
			ST_LONG: begin
				if (act) begin
					ev = EV_LHOLD;
				end else begin
					ev      = EV_LSTOP;
					state_d = ST_UP;
				end
			end
			ST_UP: begin
				if (diff <= tap_term && tap_q != 8'hFF) tap_d = tap_q + 8'd1;
				ev           = EV_UP;
				event_tick_d = tick;
				state_d      = ST_RELEASED;
			end
			ST_RELEASED: begin
				if (act) begin
					state_d = ST_DOWN;
				end else if (diff > tap_term) begin
					// The tap report shows the count before it is cleared.
					if (cfg.event_enable[EV_TAP-EV_UP] && tap_q != 8'd0) begin
						ev        = EV_TAP;
						tap_shown = 1'b1;
						tap_d     = '0;
					end
					state_d      = ST_IDLE;
					event_tick_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		event_res = ev;
		if (ev != EV_NONE && !cfg.event_enable[ev-EV_UP]) event_res = EV_NONE;
		tap_count = tap_shown ? tap_q : tap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			event_tick_q <= '0;
			tap_q        <= '0;
		end else if (clr.clear) begin
			state_q      <= ST_INIT;
			event_tick_q <= '0;
			tap_q        <= '0;
		end else if (step) begin
			state_q      <= state_d;
			event_tick_q <= event_tick_d;
			tap_q        <= tap_d;
		end
	end

endmodule

FILE: hdl/button_event_detector.sv
// Channel   Direction  Contents
// s_*       in         tdata: tick [31:0], raw_level [32]
// m_*       out        tdata: tap_count [7:0], stable_level [8]; tuser: event_res [2:0]
// cfg_*     in         cfg_index selects the register, cfg_data holds the value
//
// One sample per clock is sustained while m_tready does not stall the result register;
// each sample passes through the sample register and then the result register.
// The sample register feeds a single compute stage that updates the debouncer and the
// button state machine and loads the result register in the same cycle.
// A stalled m_tready holds the result; the sample register still accepts an item if it is empty.
// Reset and any write to a known register return the detector to its start state.
module button_event_detector #(
	parameter int TICK_WIDTH = bed_pkg::TickWidthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,   // tick, raw_level
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // tap_count, stable_level
	output bed_pkg::event_t               m_tuser,   // event_res
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bed_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [bed_pkg::CfgDataW-1:0]  cfg_data
);
	import bed_pkg::*;

	cfg_t                  cfg;
	clr_t                  clr;
	logic [TICK_WIDTH-1:0] tick_in;

	logic                  valid_s1;
	logic [TICK_WIDTH-1:0] tick_s1;
	logic                  lvl_s1;

	logic                  valid_s2;
	event_t                ev_s2;
	logic [7:0]            tap_s2;
	logic                  lvl_s2;

	logic                  advance;
	logic                  step;
	logic                  level;
	event_t                ev;
	logic [7:0]            tap;

	generate
		if (TICK_WIDTH > TickInW) begin : g_tick_ext
			assign tick_in = {{(TICK_WIDTH-TickInW){1'b0}}, s_tdata[TickInW-1:0]};
		end else begin : g_tick_cut
			assign tick_in = s_tdata[TICK_WIDTH-1:0];
		end
	endgenerate

	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	bed_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.clr       (clr)
	);

	bed_debounce #(.TICK_WIDTH(TICK_WIDTH)) u_debounce (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clr       (clr),
		.step      (step),
		.tick      (tick_s1),
		.raw_level (lvl_s1),
		.level     (level)
	);

	bed_fsm #(.TICK_WIDTH(TICK_WIDTH)) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clr       (clr),
		.step      (step),
		.tick      (tick_s1),
		.act       (level == cfg.press_level),
		.event_res (ev),
		.tap_count (tap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= tick_in;
			lvl_s1  <= s_tdata[TickInW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_s2  <= ev;
			tap_s2 <= tap;
			lvl_s2 <= level;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, lvl_s2, tap_s2};
	assign m_tuser  = ev_s2;

endmodule
